[hw/rtl/small_fast_prng_32_defines.svh]
// Assertion macros shared by the small fast PRNG RTL.
`ifndef SMALL_FAST_PRNG_32_DEFINES_SVH
`define SMALL_FAST_PRNG_32_DEFINES_SVH

// Same-cycle implication, checked on aclk outside reset.
`define SFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define SFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/sfp_pkg.sv]
// Types and constants of the small fast PRNG.
package sfp_pkg;

    localparam int WORD_W = 32;
    localparam int CNT_W  = 6;
    localparam int ROT_B  = 27;
    localparam int ROT_C  = 17;

    localparam logic [WORD_W-1:0] SEED_A = 32'hf1ea5eed;

    localparam logic CMD_RESEED = 1'b0;
    localparam logic CMD_DRAW   = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] d;
    } sfp_state_t;

endpackage

[hw/rtl/sfp_round.sv]
// One generator round: subtract, xor and three adds with fixed rotates.
module sfp_round
    import sfp_pkg::*;
(
    input  sfp_state_t cur,
    output sfp_state_t nxt
);

    logic [WORD_W-1:0] rot_b;
    logic [WORD_W-1:0] rot_c;
    logic [WORD_W-1:0] e;
    logic [WORD_W-1:0] a_new;

    assign rot_b = {cur.b[WORD_W-ROT_B-1:0], cur.b[WORD_W-1:WORD_W-ROT_B]};
    assign rot_c = {cur.c[WORD_W-ROT_C-1:0], cur.c[WORD_W-1:WORD_W-ROT_C]};
    assign e     = cur.a - rot_b;
    assign a_new = cur.b ^ rot_c;

    assign nxt.a = a_new;
    assign nxt.b = cur.c + cur.d;
    assign nxt.c = cur.d + e;
    assign nxt.d = e + a_new;

endmodule

[hw/rtl/small_fast_prng_32.sv]
// Small fast PRNG top level: request register, state with round logic, result register.
// A draw request passes the request register, then the result register, to m_tdata.
// Throughput: one draw per cycle, set by the single round unit on the state registers,
// with m_tready high. A reseed holds the request stage over WARMUP_ROUNDS warm-up rounds.
// Reset (aresetn low, synchronous) clears all state words to zero and empties both stages.
module small_fast_prng_32
    import sfp_pkg::*;
#(
    parameter int WARMUP_ROUNDS = 31
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [WORD_W-1:0] s_tdata,   // [31:0] seed
    input  logic              s_tuser,   // [0] cmd: 0 reseed, 1 draw
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [WORD_W-1:0] m_tdata    // [31:0] value
);

`include "small_fast_prng_32_defines.svh"

    localparam logic [CNT_W-1:0] WARMUP_LIM = CNT_W'(WARMUP_ROUNDS);

    logic              in_valid_reg;
    logic              in_cmd_reg;
    logic [WORD_W-1:0] in_seed_reg;

    sfp_state_t        st_reg;
    sfp_state_t        st_next;
    sfp_state_t        rnd_out;

    logic              warm_reg;
    logic              warm_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;

    logic              out_valid_reg;
    logic [WORD_W-1:0] out_data_reg;

    logic              out_free;
    logic              take;
    logic              take_draw;
    logic              take_seed;

    sfp_round u_round (
        .cur (st_reg),
        .nxt (rnd_out)
    );

    assign out_free  = !out_valid_reg || m_tready;
    assign take      = in_valid_reg && !warm_reg && (in_cmd_reg == CMD_RESEED || out_free);
    assign take_draw = take && (in_cmd_reg == CMD_DRAW);
    assign take_seed = take && (in_cmd_reg == CMD_RESEED);
    assign s_tready  = !in_valid_reg || take;

    always_comb begin
        st_next   = st_reg;
        warm_next = warm_reg;
        cnt_next  = cnt_reg;
        if (take_seed) begin
            st_next.a = SEED_A;
            st_next.b = in_seed_reg;
            st_next.c = in_seed_reg;
            st_next.d = in_seed_reg;
            cnt_next  = '0;
            warm_next = (WARMUP_LIM != '0);
        end else if (warm_reg) begin
            st_next   = rnd_out;
            cnt_next  = cnt_reg + 1'b1;
            warm_next = (cnt_next != WARMUP_LIM);
        end else if (take_draw) begin
            st_next = rnd_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            in_cmd_reg    <= CMD_DRAW;
            st_reg        <= '0;
            warm_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
                in_cmd_reg   <= s_tuser;
            end
            st_reg   <= st_next;
            warm_reg <= warm_next;
            cnt_reg  <= cnt_next;
            if (take_draw) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            in_seed_reg <= s_tdata;
        end
        if (take_draw) begin
            out_data_reg <= rnd_out.d;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `SFP_ASSERT_NOW(a_no_take_in_warmup, warm_reg, !take, "request taken during warm-up")
    `SFP_ASSERT_NOW(a_cnt_in_range, warm_reg, cnt_reg < WARMUP_LIM, "warm-up count past limit")
    `SFP_ASSERT_NEXT(a_draw_gives_result, take_draw, out_valid_reg, "draw gave no result")
    `SFP_ASSERT_NEXT(a_seed_no_result, take_seed && out_valid_reg && m_tready, !out_valid_reg,
        "reseed produced a result")

endmodule
